// ===== sv/blci_pkg.sv =====
// shared constants and types for the line rasterizer with colour interpolation
`default_nettype none
package blci_pkg;
    // command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // divider control from the sequencer
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;
endpackage
`default_nettype wire

// ===== sv/blci_div.sv =====
// restoring divider, one quotient bit per cycle, unsigned magnitude
`default_nettype none
module blci_div #(
    parameter int NUM_BITS = 24,
    parameter int DEN_BITS = 13
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire blci_pkg::t_div_ctrl           i_ctrl,
    input  wire logic [NUM_BITS-1:0]           i_num,
    input  wire logic [DEN_BITS-1:0]           i_den,
    output blci_pkg::t_div_stat                o_stat,
    output logic [NUM_BITS-1:0]                o_quot
);
    import blci_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quot;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy, r_done;
    logic [DEN_BITS+1:0] w_trial;
    logic [DEN_BITS+1:0] w_shift;

    // one shift-subtract step
    always_comb begin
        w_shift = {r_rem, r_quot[NUM_BITS-1]};
        w_trial = w_shift - {2'b00, r_den};
    end

    // iteration control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_trial[DEN_BITS+1]) begin
                    r_rem  <= w_trial[DEN_BITS:0];
                    r_quot <= {r_quot[NUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= w_shift[DEN_BITS:0];
                    r_quot <= {r_quot[NUM_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;
endmodule
`default_nettype wire

// ===== sv/bresenham_line_color_interp.sv =====
// top level: line stepper, colour sequencer and output register
`default_nettype none
// Bresenham line rasterizer with linear RGB interpolation. A start word loads
// the endpoints and both colours and yields the first pixel; each advance word
// yields the next pixel along the major axis, the final one flagged on tlast.
// An advance with no active line yields nothing. The three colour channels
// run one after another through a single bit-serial divider that produces one
// quotient bit per cycle; each channel passes through the numerator stage,
// the divider launch, the divider steps and the wait for done. A start word
// with equal endpoints skips the divider. The next word is accepted while a
// finished result still waits on the output; its own result then stalls until
// the waiting word is taken.
module bresenham_line_color_interp #(
    parameter int COORD_BITS   = 12,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata fields from bit 0: x_start, y_start, x_end, y_end,
    // red_a, green_a, blue_a, red_b, green_b, blue_b
    input  wire logic [((4*COORD_BITS+6*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser fields: cmd
    input  wire logic                                 s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata fields from bit 0: pixel_x, pixel_y, red, green, blue
    output logic [((2*COORD_BITS+3*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata,
    // last flag of the line
    output logic                                      m_axis_tlast
);
    import blci_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int HB = CHANNEL_BITS;
    localparam int DB = CB + 1;              // delta width
    localparam int EB = CB + 3;              // error term width
    localparam int NB = HB + DB;             // numerator magnitude width
    localparam int OW = ((2*CB+3*HB+7)/8)*8;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;

    logic [2:0]        r_state;
    logic [1:0]        r_ch;
    logic signed [CB-1:0] r_cur_x, r_cur_y;
    logic signed [EB-1:0] r_err;
    logic [DB-1:0]     r_steps, r_dmaj, r_dmin;
    logic              r_sx, r_sy, r_ymaj, r_active;
    logic [HB-1:0]     r_ca [3];
    logic [HB-1:0]     r_cb [3];
    logic [HB-1:0]     r_res [3];
    logic [NB-1:0]     r_num;
    logic              r_neg;
    logic              w_emit;
    logic [OW-1:0]     r_odata;
    logic              r_ovalid, r_olast;

    t_div_ctrl         w_dctl;
    t_div_stat         w_dstat;
    logic [NB-1:0]     w_quot;

    // unpacked input fields
    logic              w_cmd;
    logic signed [CB-1:0] w_x1, w_y1, w_x2, w_y2;
    logic signed [CB:0] w_ddx, w_ddy;
    logic [DB-1:0]     w_dx, w_dy;
    logic signed [HB:0] w_diff;
    logic signed [NB:0] w_prod;
    logic              w_maj_step, w_move;

    assign w_cmd = s_axis_tuser;
    assign w_x1  = s_axis_tdata[CB-1:0];
    assign w_y1  = s_axis_tdata[2*CB-1:CB];
    assign w_x2  = s_axis_tdata[3*CB-1:2*CB];
    assign w_y2  = s_axis_tdata[4*CB-1:3*CB];
    assign w_ddx = {w_x2[CB-1], w_x2} - {w_x1[CB-1], w_x1};
    assign w_ddy = {w_y2[CB-1], w_y2} - {w_y1[CB-1], w_y1};
    assign w_dx  = w_ddx[CB] ? DB'(-w_ddx) : DB'(w_ddx);
    assign w_dy  = w_ddy[CB] ? DB'(-w_ddy) : DB'(w_ddy);

    // colour numerator for the channel in turn: (cb - ca) * steps
    assign w_diff = $signed({1'b0, r_cb[r_ch]}) - $signed({1'b0, r_ca[r_ch]});
    assign w_prod = w_diff * $signed({1'b0, r_steps});

    assign w_move = (r_err > 0);
    assign w_maj_step = 1'b1;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_dctl.start  = (r_state == ST_DIV);

    blci_div #(.NUM_BITS(NB), .DEN_BITS(DB)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_dctl),
        .i_num  (r_num),
        .i_den  (r_dmaj),
        .o_stat (w_dstat),
        .o_quot (w_quot)
    );

    // sequencer and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
            r_ch     <= '0;
            r_cur_x  <= '0; r_cur_y <= '0; r_err <= '0;
            r_steps  <= '0; r_dmaj  <= '0; r_dmin <= '0;
            r_sx <= 1'b0; r_sy <= 1'b0; r_ymaj <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_ca[k] <= '0;
                r_cb[k] <= '0;
            end
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        if (w_cmd == CMD_START) begin
                            for (int k = 0; k < 3; k++) begin
                                r_ca[k] <= s_axis_tdata[4*CB+k*HB +: HB];
                                r_cb[k] <= s_axis_tdata[4*CB+(k+3)*HB +: HB];
                            end
                            r_sx <= w_ddx[CB]; r_sy <= w_ddy[CB];
                            r_ymaj <= (w_dy > w_dx);
                            if (w_dy > w_dx) begin
                                r_dmaj <= w_dy; r_dmin <= w_dx;
                                r_err <= EB'({w_dx, 1'b0}) - EB'(w_dy);
                            end else begin
                                r_dmaj <= w_dx; r_dmin <= w_dy;
                                r_err <= EB'({w_dy, 1'b0}) - EB'(w_dx);
                            end
                            r_steps  <= '0;
                            r_cur_x  <= w_x1; r_cur_y <= w_y1;
                            r_active <= (w_dx != '0) || (w_dy != '0);
                            r_ch     <= '0;
                            r_state  <= ST_MUL;
                        end else if (r_active) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                // one Bresenham step
                ST_LOAD: begin
                    if (w_move)
                        r_err <= r_err + EB'({r_dmin, 1'b0}) - EB'({r_dmaj, 1'b0});
                    else
                        r_err <= r_err + EB'({r_dmin, 1'b0});
                    if (r_ymaj) begin
                        r_cur_y <= r_sy ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                        if (w_move) r_cur_x <= r_sx ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                    end else begin
                        r_cur_x <= r_sx ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                        if (w_move) r_cur_y <= r_sy ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                    end
                    r_steps <= r_steps + DB'(w_maj_step);
                    if (r_steps + DB'(1) >= r_dmaj) r_active <= 1'b0;
                    r_ch    <= '0;
                    r_state <= ST_MUL;
                end
                // register the numerator, or take colour a directly for a zero-length line
                ST_MUL: begin
                    if (r_dmaj == '0) begin
                        for (int k = 0; k < 3; k++) r_res[k] <= r_ca[k];
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                // launch the divider on the registered numerator
                ST_DIV: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_dstat.done) begin
                        r_res[r_ch] <= r_neg ? r_ca[r_ch] - HB'(w_quot)
                                             : r_ca[r_ch] + HB'(w_quot);
                        if (r_ch == 2'd2) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // numerator magnitude, one stage ahead of the divider
    always_ff @(posedge i_clk) begin
        r_neg <= w_prod[NB];
        r_num <= w_prod[NB] ? NB'(-w_prod) : NB'(w_prod);
    end

    // output word
    always_comb begin
        w_emit = (r_state == ST_OUT) && !r_ovalid;
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_odata <= OW'({r_res[2], r_res[1], r_res[0], r_cur_y, r_cur_x});
            r_olast <= (r_steps >= r_dmaj);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
endmodule
`default_nettype wire

// ===== tb/bresenham_line_color_interp_tb.sv =====
// testbench for the line rasterizer with colour interpolation
`timescale 1ns / 1ps
module bresenham_line_color_interp_tb;
    import blci_pkg::*;

    localparam int CB = 12;
    localparam int HB = 8;
    localparam int COLS_W = 6*HB;
    localparam int IN_W = ((4*CB+6*HB+7)/8)*8;
    localparam int OUT_W = ((2*CB+3*HB+7)/8)*8;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic [HB-1:0] r;
        logic [HB-1:0] g;
        logic [HB-1:0] b;
        logic last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = CMD_ADVANCE;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    bresenham_line_color_interp i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // rasterizer state mirror
    int cur_x, cur_y, err, steps, dmaj, dmin;
    bit neg_x, neg_y, ymaj, line_on;
    int col_a[3], col_b[3];

    t_pixel pixel_queue[$];
    int errors = 0;
    int idle_cycles = 0;
    bit random_idle = 1'b1;
    bit hold_off = 1'b0;
    bit long_hold = 1'b0;

    function automatic logic [HB-1:0] mix(int ch);
        longint num, mag, q;
        if (dmaj <= 0) return HB'(col_a[ch]);
        num = longint'(col_b[ch] - col_a[ch]) * steps;
        mag = num < 0 ? -num : num;
        q = mag / dmaj;
        return num < 0 ? HB'(col_a[ch] - q) : HB'(col_a[ch] + q);
    endfunction

    function automatic t_pixel make_pixel();
        t_pixel p;
        p.px = cur_x[CB-1:0];
        p.py = cur_y[CB-1:0];
        p.r = mix(0);
        p.g = mix(1);
        p.b = mix(2);
        p.last = steps >= dmaj;
        return p;
    endfunction

    // advance the mirror for one accepted word
    task automatic predict_pixel(logic cmd, logic [IN_W-1:0] d);
        int x1, y1, x2, y2, dx, dy;
        bit mv;
        if (cmd == CMD_START) begin
            x1 = $signed(d[0 +: CB]);
            y1 = $signed(d[CB +: CB]);
            x2 = $signed(d[2*CB +: CB]);
            y2 = $signed(d[3*CB +: CB]);
            for (int k = 0; k < 3; k++) begin
                col_a[k] = d[4*CB + k*HB +: HB];
                col_b[k] = d[4*CB + (k+3)*HB +: HB];
            end
            dx = x2 >= x1 ? x2 - x1 : x1 - x2;
            dy = y2 >= y1 ? y2 - y1 : y1 - y2;
            neg_x = x2 < x1;
            neg_y = y2 < y1;
            ymaj = dy > dx;
            dmaj = ymaj ? dy : dx;
            dmin = ymaj ? dx : dy;
            err = 2*dmin - dmaj;
            steps = 0;
            cur_x = x1;
            cur_y = y1;
            line_on = dmaj != 0;
            pixel_queue.push_back(make_pixel());
        end else if (line_on) begin
            mv = err > 0;
            err += mv ? 2*(dmin - dmaj) : 2*dmin;
            if (ymaj) begin
                cur_y += neg_y ? -1 : 1;
                if (mv) cur_x += neg_x ? -1 : 1;
            end else begin
                cur_x += neg_x ? -1 : 1;
                if (mv) cur_y += neg_y ? -1 : 1;
            end
            steps++;
            pixel_queue.push_back(make_pixel());
            if (steps >= dmaj) line_on = 1'b0;
        end
    endtask

    // send one word, at times after a random gap; valid drops only during a gap
    task automatic send_word(logic cmd, logic [IN_W-1:0] d);
        if (random_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(cmd, d);
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pack_start(int x1, int y1, int x2, int y2,
                                                   logic [6*HB-1:0] cols);
        logic [IN_W-1:0] d;
        d = '0;
        d[0 +: CB] = CB'(x1);
        d[CB +: CB] = CB'(y1);
        d[2*CB +: CB] = CB'(x2);
        d[3*CB +: CB] = CB'(y2);
        d[4*CB +: 6*HB] = cols;
        return d;
    endfunction

    function automatic logic [6*HB-1:0] rand_cols();
        return COLS_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [IN_W-1:0] rand_word();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    // draw a whole line, optionally followed by extra advance words
    task automatic draw_line(int x1, int y1, int x2, int y2, logic [6*HB-1:0] cols,
                             int extra);
        send_word(CMD_START, pack_start(x1, y1, x2, y2, cols));
        while (line_on) send_word(CMD_ADVANCE, rand_word());
        repeat (extra) send_word(CMD_ADVANCE, rand_word());
    endtask

    // random coordinate near the base point, clamped to the coordinate range
    function automatic int near(int base, int span);
        int v;
        v = base + $signed($urandom_range(0, 2*span)) - span;
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return v;
    endfunction

    // receiver: random stalls, compare against oldest expectation
    always @(negedge i_clk) begin
        if (hold_off || long_hold) m_axis_tready <= 1'b0;
        else if (random_idle && $urandom_range(0, 7) == 0) m_axis_tready <= 1'b0;
        else m_axis_tready <= 1'b1;
    end

    initial begin : stall_bursts
        forever begin
            @(negedge i_clk);
            if (random_idle && !hold_off && $urandom_range(0, 40) == 0) begin
                hold_off = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                hold_off = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel exp_p;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_queue.size() == 0) begin
                $display("%0t: unexpected pixel %h last %b", $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                exp_p = pixel_queue.pop_front();
                if (m_axis_tdata[0 +: CB] !== exp_p.px) begin
                    $display("%0t: x exp %0d got %0d", $time, exp_p.px,
                             $signed(m_axis_tdata[0 +: CB]));
                    errors++;
                end
                if (m_axis_tdata[CB +: CB] !== exp_p.py) begin
                    $display("%0t: y exp %0d got %0d", $time, exp_p.py,
                             $signed(m_axis_tdata[CB +: CB]));
                    errors++;
                end
                if (m_axis_tdata[2*CB +: HB] !== exp_p.r) begin
                    $display("%0t: red exp %0d got %0d", $time, exp_p.r,
                             m_axis_tdata[2*CB +: HB]);
                    errors++;
                end
                if (m_axis_tdata[2*CB+HB +: HB] !== exp_p.g) begin
                    $display("%0t: green exp %0d got %0d", $time, exp_p.g,
                             m_axis_tdata[2*CB+HB +: HB]);
                    errors++;
                end
                if (m_axis_tdata[2*CB+2*HB +: HB] !== exp_p.b) begin
                    $display("%0t: blue exp %0d got %0d", $time, exp_p.b,
                             m_axis_tdata[2*CB+2*HB +: HB]);
                    errors++;
                end
                if (m_axis_tlast !== exp_p.last) begin
                    $display("%0t: last exp %b got %b", $time, exp_p.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // extremes, octants, degenerate and idle advances
    task automatic test_directed();
        send_word(CMD_ADVANCE, '1);
        send_word(CMD_START, pack_start(5, -7, 5, -7, {48{1'b1}}));
        send_word(CMD_ADVANCE, '0);
        send_word(CMD_START, pack_start(-2048, -2048, 2047, 2047,
                                        {8'hff, 8'h00, 8'h80, 8'h00, 8'hff, 8'h7f}));
        repeat (20) send_word(CMD_ADVANCE, rand_word());
        draw_line(0, 0, 5, 2, {8'h00, 8'hff, 8'h10, 8'hff, 8'h00, 8'hf0}, 1);
        draw_line(0, 0, -3, 7, rand_cols(), 0);
        draw_line(4, 4, -2, 1, rand_cols(), 0);
        draw_line(-1, 3, 2, -4, rand_cols(), 0);
        draw_line(0, 0, 4, 4, rand_cols(), 0);
        draw_line(10, 0, 10, 3, rand_cols(), 0);
        draw_line(2047, 2047, 2040, 2047, '0, 0);
        draw_line(-2048, 2047, -2048, 2040, {48{1'b1}}, 0);
        draw_line(-100, 50, 100, -30, {8'hff, 8'h00, 8'h80, 8'h00, 8'hff, 8'h7f}, 0);
    endtask

    // a start arriving in the middle of a line
    task automatic test_restart();
        send_word(CMD_START, pack_start(0, 0, 9, 5, rand_cols()));
        send_word(CMD_ADVANCE, rand_word());
        send_word(CMD_ADVANCE, rand_word());
        draw_line(1, 1, -6, 2, rand_cols(), 0);
    endtask

    // receiver held off long enough for the input to stall
    task automatic test_backpressure();
        fork
            begin
                long_hold = 1'b1;
                repeat (600) @(negedge i_clk);
                long_hold = 1'b0;
            end
            draw_line(0, 0, 3, -6, rand_cols(), 0);
        join
    endtask

    // random lines, mostly short, some cut short or with noise
    task automatic test_random(int words);
        int sent, x1, y1, sel;
        sent = 0;
        while (sent < words) begin
            sel = $urandom_range(0, 19);
            x1 = $signed($urandom_range(0, 4095)) - 2048;
            y1 = $signed($urandom_range(0, 4095)) - 2048;
            if (sel == 0) begin
                send_word(1'($urandom_range(0, 1)), rand_word());
                sent++;
            end else if (sel == 1) begin
                send_word(CMD_START, pack_start(x1, y1, near(x1, 20), near(y1, 20),
                                                rand_cols()));
                repeat ($urandom_range(0, 3)) send_word(CMD_ADVANCE, rand_word());
                sent += 4;
            end else begin
                draw_line(x1, y1, near(x1, 12), near(y1, 12), rand_cols(),
                          $urandom_range(0, 1));
                sent += dmaj + 2;
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_restart();
        test_backpressure();
        test_random(750);
        random_idle = 1'b0;
        test_random(200);
        s_axis_tvalid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
